// File: rtl/assert_macros.svh
// Assertion macros shared by the tracker-to-MIDI RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/trk2m_pkg.sv
// Shared types, constants and helpers for the tracker-to-MIDI converter.
// No dependencies; used by every RTL module of the block.
package trk2m_pkg;

    // sizing
    localparam int CHANNELS   = 4;   // 1..4
    localparam int HOLD_DEPTH = 4;   // 1..16
    localparam int CHI_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIDX_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);
    localparam int CCN_W      = 49;

    // link byte codes
    localparam logic [6:0] BYTE_VALUE_MAX = 7'h6F;
    localparam logic [6:0] BYTE_CLOCK     = 7'h7F;
    localparam logic [6:0] BYTE_STOP      = 7'h7E;
    localparam logic [6:0] BYTE_START     = 7'h7D;

    // command groups (upper two bits of the latched command)
    localparam logic [1:0] CMDG_NOTE = 2'd0;
    localparam logic [1:0] CMDG_CC   = 2'd1;
    localparam logic [1:0] CMDG_PROG = 2'd2;
    localparam logic [1:0] CMDG_NONE = 2'd3;
    localparam logic [3:0] CMD_RESET = 4'hF;

    // MIDI data constants
    localparam logic [6:0] CC_ALL_OFF = 7'h7B;
    localparam logic [6:0] DATA_MAX   = 7'h7F;
    localparam logic [2:0] CC_IDX_MAX = 3'd6;

    // result kinds
    localparam logic [2:0] MK_NOTE_ON  = 3'd0;
    localparam logic [2:0] MK_NOTE_OFF = 3'd1;
    localparam logic [2:0] MK_CC       = 3'd2;
    localparam logic [2:0] MK_PROG     = 3'd3;
    localparam logic [2:0] MK_START    = 3'd4;
    localparam logic [2:0] MK_STOP     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_SPLIT = 3'd0;
    localparam logic [2:0] CFG_SCALE = 3'd1;
    localparam logic [2:0] CFG_CCN0  = 3'd2;
    localparam logic [2:0] CFG_CCN1  = 3'd3;
    localparam logic [2:0] CFG_CCN2  = 3'd4;
    localparam logic [2:0] CFG_CCN3  = 3'd5;
    localparam logic [2:0] CFG_HOLD  = 3'd6;

    localparam logic [CCN_W-1:0] CCN_RESET  = 49'd53157214339329;
    localparam logic [15:0]      HOLD_RESET = 16'd10;

    // floor(v*127/111) == (v * 127 * 18894) >> 21, exact for v < 128
    localparam logic [21:0] CC_SCALE_MUL = 22'd2399538;

    typedef enum logic [2:0] {
        JK_NOTE,
        JK_CC,
        JK_PROG,
        JK_START,
        JK_STOP
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  ch;
        logic [6:0]  val;
        logic [31:0] stamp;
    } t_job;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       last;
    } t_msg;

    function automatic logic [6:0] cc_scale(input logic [6:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(CC_SCALE_MUL);
        return (p[28:21] > 8'(DATA_MAX)) ? DATA_MAX : p[27:21];
    endfunction

endpackage

// File: rtl/trk2m_front.sv
// Front end: accepts link bytes and ticks, keeps time and the command latch,
// and turns complete commands into jobs. Depends on trk2m_pkg.
module trk2m_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_func,
    input  logic [6:0]        i_rx_byte,
    input  logic              i_q_full,
    output logic              o_q_push,
    output trk2m_pkg::t_job   o_q_job
);

    logic [31:0] r_now_ms, n_now_ms;
    logic [3:0]  r_pending, n_pending;
    logic        r_expect, n_expect;
    logic        w_accept;
    logic        w_ch_ok;

    assign w_accept = i_push && !i_q_full;
    assign w_ch_ok  = ({1'b0, r_pending[1:0]} < 3'(trk2m_pkg::CHANNELS));

    always_comb begin
        n_now_ms      = r_now_ms;
        n_pending     = r_pending;
        n_expect      = r_expect;
        o_q_push      = 1'b0;
        o_q_job.kind  = trk2m_pkg::JK_NOTE;
        o_q_job.ch    = r_pending[1:0];
        o_q_job.val   = i_rx_byte;
        o_q_job.stamp = r_now_ms;
        if (w_accept) begin
            if (i_func) begin
                n_now_ms = 32'(r_now_ms + 32'd1);
            end else if (i_rx_byte > trk2m_pkg::BYTE_VALUE_MAX) begin
                if (i_rx_byte == trk2m_pkg::BYTE_STOP) begin
                    o_q_push     = 1'b1;
                    o_q_job.kind = trk2m_pkg::JK_STOP;
                end else if (i_rx_byte == trk2m_pkg::BYTE_START) begin
                    o_q_push     = 1'b1;
                    o_q_job.kind = trk2m_pkg::JK_START;
                end else if (i_rx_byte != trk2m_pkg::BYTE_CLOCK) begin
                    n_pending = i_rx_byte[3:0];
                    n_expect  = 1'b1;
                end
            end else if (r_expect) begin
                n_expect = 1'b0;
                unique case (r_pending[3:2])
                    trk2m_pkg::CMDG_NOTE: begin
                        o_q_push     = w_ch_ok;
                        o_q_job.kind = trk2m_pkg::JK_NOTE;
                    end
                    trk2m_pkg::CMDG_CC: begin
                        o_q_push     = w_ch_ok;
                        o_q_job.kind = trk2m_pkg::JK_CC;
                    end
                    trk2m_pkg::CMDG_PROG: begin
                        o_q_push     = w_ch_ok;
                        o_q_job.kind = trk2m_pkg::JK_PROG;
                    end
                    default: o_q_push = 1'b0;   // commands 12..15 swallow the value
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms  <= '0;
            r_pending <= trk2m_pkg::CMD_RESET;
            r_expect  <= 1'b0;
        end else begin
            r_now_ms  <= n_now_ms;
            r_pending <= n_pending;
            r_expect  <= n_expect;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_tick_advances, i_clk, i_rst_n, w_accept && i_func, r_now_ms == 32'($past(r_now_ms) + 32'd1), "tick did not advance time")

endmodule

// File: rtl/trk2m_jobq.sv
// Short job queue between front end and sequencer, flip-flop slots.
// Depends on trk2m_pkg.
module trk2m_jobq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trk2m_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output trk2m_pkg::t_job   o_head
);

    localparam int PW = (trk2m_pkg::JOBQ_PW > 0) ? trk2m_pkg::JOBQ_PW : 1;

    trk2m_pkg::t_job                r_slot [trk2m_pkg::JOBQ_DEPTH];
    logic [PW-1:0]                  r_wp, r_rp;
    logic [trk2m_pkg::JOBQ_CW-1:0]  r_count;
    logic                           w_do_push, w_do_pop;

    assign o_full    = (r_count == trk2m_pkg::JOBQ_CW'(trk2m_pkg::JOBQ_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_slot[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(trk2m_pkg::JOBQ_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= bump(r_wp);
            end
            if (w_do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= trk2m_pkg::JOBQ_CW'(r_count + 1'b1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= trk2m_pkg::JOBQ_CW'(r_count - 1'b1);
            end
        end
    end

    `include "assert_macros.svh"

    `ASSERT_AT(a_no_push_when_full, i_clk, i_rst_n, !(i_push && o_full), "job pushed into full queue")

endmodule

// File: rtl/trk2m_back.sv
// Sequencer: runs jobs, tracks held notes per channel, owns the config
// registers and the result register. Depends on trk2m_pkg.
module trk2m_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [48:0]       i_cfg_data,
    input  logic              i_q_empty,
    input  trk2m_pkg::t_job   i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_out_valid,
    output trk2m_pkg::t_msg   o_out
);

    localparam int CHN = trk2m_pkg::CHANNELS;
    localparam int HD  = trk2m_pkg::HOLD_DEPTH;
    localparam int CW  = trk2m_pkg::HOLD_CW;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_FLUSH   = 6'b000100,
        S_NOTE_ON = 6'b001000,
        S_SINGLE  = 6'b010000,
        S_STOP    = 6'b100000
    } t_state;

    // config
    logic [CHN-1:0]  r_split, r_scale;
    logic [trk2m_pkg::CCN_W-1:0] r_ccn [CHN];
    logic [15:0]     r_hold_ms;

    // per-channel note tracking
    logic [31:0]     r_start    [CHN];
    logic [31:0]     n_start    [CHN];
    logic [CW-1:0]   r_count    [CHN];
    logic [CW-1:0]   n_count    [CHN];
    logic [CHN-1:0]  r_sounding, n_sounding;
    logic [6:0]      r_held     [CHN][HD];

    // sequencer
    t_state          r_state, n_state;
    trk2m_pkg::t_job r_job, n_job;
    logic [CW-1:0]   r_k, n_k;
    logic [1:0]      r_ch, n_ch;
    logic            r_then_on, n_then_on;
    logic            r_go_stop, n_go_stop;
    trk2m_pkg::t_msg r_single, n_single;

    // result register
    logic            r_out_valid;
    trk2m_pkg::t_msg r_out;

    logic            w_out_free;
    logic            w_emit;
    trk2m_pkg::t_msg w_msg;
    logic            w_held_we;
    logic [trk2m_pkg::CHI_W-1:0] w_jc, w_sc;
    logic [31:0]     w_age;
    logic            w_expired;
    logic [2:0]      w_cc_idx;
    logic [6:0]      w_cc_val;
    logic            w_cnt_ok;

    assign w_out_free  = !r_out_valid || i_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_jc        = r_job.ch[trk2m_pkg::CHI_W-1:0];
    assign w_sc        = r_ch[trk2m_pkg::CHI_W-1:0];
    assign w_age       = r_job.stamp - r_start[w_jc];
    assign w_expired   = (w_age > {16'b0, r_hold_ms});

    // control change selection: split mode picks one of seven numbers
    always_comb begin
        w_cc_idx = '0;
        w_cc_val = r_job.val;
        if (r_split[w_jc]) begin
            w_cc_idx = r_job.val[6:4];
            if (r_scale[w_jc]) begin
                w_cc_val = {r_job.val[3:0], 3'b000};
            end
        end else if (r_scale[w_jc]) begin
            w_cc_val = trk2m_pkg::cc_scale(r_job.val);
        end
        if (w_cc_idx > trk2m_pkg::CC_IDX_MAX) begin
            w_cc_idx = trk2m_pkg::CC_IDX_MAX;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_k        = r_k;
        n_ch       = r_ch;
        n_then_on  = r_then_on;
        n_go_stop  = r_go_stop;
        n_single   = r_single;
        n_start    = r_start;
        n_count    = r_count;
        n_sounding = r_sounding;
        o_q_pop    = 1'b0;
        w_emit     = 1'b0;
        w_held_we  = 1'b0;
        w_msg      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_head;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_single      = '0;
                n_single.last = 1'b1;
                n_go_stop     = 1'b0;
                n_k           = '0;
                unique case (r_job.kind)
                    trk2m_pkg::JK_START: begin
                        n_single.kind = trk2m_pkg::MK_START;
                        n_state       = S_SINGLE;
                    end
                    trk2m_pkg::JK_STOP: begin
                        n_single.kind = trk2m_pkg::MK_STOP;
                        n_single.last = 1'b0;
                        n_go_stop     = 1'b1;
                        n_state       = S_SINGLE;
                    end
                    trk2m_pkg::JK_PROG: begin
                        n_single.kind = trk2m_pkg::MK_PROG;
                        n_single.ch   = r_job.ch;
                        n_single.d1   = r_job.val;
                        n_state       = S_SINGLE;
                    end
                    trk2m_pkg::JK_CC: begin
                        n_single.kind = trk2m_pkg::MK_CC;
                        n_single.ch   = r_job.ch;
                        n_single.d1   = r_ccn[w_jc][w_cc_idx*7 +: 7];
                        n_single.d2   = w_cc_val;
                        n_state       = S_SINGLE;
                    end
                    trk2m_pkg::JK_NOTE: begin
                        if (r_job.val != '0) begin
                            // flush first when the hold time has run out
                            if (w_expired && r_count[w_jc] != '0) begin
                                n_then_on = 1'b1;
                                n_state   = S_FLUSH;
                            end else begin
                                n_state   = S_NOTE_ON;
                            end
                        end else if (r_sounding[w_jc]) begin
                            if (r_count[w_jc] != '0) begin
                                n_then_on = 1'b0;
                                n_state   = S_FLUSH;
                            end else begin
                                n_sounding[w_jc] = 1'b0;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_msg.kind = trk2m_pkg::MK_NOTE_OFF;
                    w_msg.ch   = r_job.ch;
                    w_msg.d1   = r_held[w_jc][r_k[trk2m_pkg::HIDX_W-1:0]];
                    n_k        = CW'(r_k + 1'b1);
                    if (r_k == CW'(r_count[w_jc] - 1'b1)) begin
                        w_msg.last       = !r_then_on;
                        n_count[w_jc]    = '0;
                        n_sounding[w_jc] = 1'b0;
                        n_state          = r_then_on ? S_NOTE_ON : S_IDLE;
                    end
                end
            end
            S_NOTE_ON: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_msg.kind = trk2m_pkg::MK_NOTE_ON;
                    w_msg.ch   = r_job.ch;
                    w_msg.d1   = r_job.val;
                    w_msg.d2   = trk2m_pkg::DATA_MAX;
                    w_msg.last = 1'b1;
                    // saturate instead of overflowing the hold list
                    if (r_count[w_jc] < CW'(HD)) begin
                        w_held_we     = 1'b1;
                        n_count[w_jc] = CW'(r_count[w_jc] + 1'b1);
                    end
                    n_start[w_jc]    = r_job.stamp;
                    n_sounding[w_jc] = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_msg   = r_single;
                    n_ch    = '0;
                    n_k     = '0;
                    n_state = r_go_stop ? S_STOP : S_IDLE;
                end
            end
            S_STOP: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_sounding[w_sc] && r_k < r_count[w_sc]) begin
                        w_msg.kind = trk2m_pkg::MK_NOTE_OFF;
                        w_msg.ch   = r_ch;
                        w_msg.d1   = r_held[w_sc][r_k[trk2m_pkg::HIDX_W-1:0]];
                        n_k        = CW'(r_k + 1'b1);
                    end else begin
                        w_msg.kind       = trk2m_pkg::MK_CC;
                        w_msg.ch         = r_ch;
                        w_msg.d1         = trk2m_pkg::CC_ALL_OFF;
                        w_msg.d2         = trk2m_pkg::DATA_MAX;
                        w_msg.last       = (r_ch == 2'(CHN - 1));
                        n_count[w_sc]    = '0;
                        n_sounding[w_sc] = 1'b0;
                        n_k              = '0;
                        n_ch             = 2'(r_ch + 1'b1);
                        if (r_ch == 2'(CHN - 1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold list store, undefined until written
    always_ff @(posedge i_clk) begin
        if (w_held_we) begin
            r_held[w_jc][r_count[w_jc][trk2m_pkg::HIDX_W-1:0]] <= r_job.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_msg;
        end
        r_job    <= n_job;
        r_single <= n_single;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_ch        <= '0;
            r_then_on   <= 1'b0;
            r_go_stop   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sounding  <= '0;
            for (int c = 0; c < CHN; c++) begin
                r_start[c] <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_ch       <= n_ch;
            r_then_on  <= n_then_on;
            r_go_stop  <= n_go_stop;
            r_sounding <= n_sounding;
            r_start    <= n_start;
            r_count    <= n_count;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split   <= '1;
            r_scale   <= '1;
            r_hold_ms <= trk2m_pkg::HOLD_RESET;
            for (int c = 0; c < CHN; c++) begin
                r_ccn[c] <= trk2m_pkg::CCN_RESET;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                trk2m_pkg::CFG_SPLIT: r_split   <= i_cfg_data[CHN-1:0];
                trk2m_pkg::CFG_SCALE: r_scale   <= i_cfg_data[CHN-1:0];
                trk2m_pkg::CFG_HOLD:  r_hold_ms <= i_cfg_data[15:0];
                trk2m_pkg::CFG_CCN0, trk2m_pkg::CFG_CCN1,
                trk2m_pkg::CFG_CCN2, trk2m_pkg::CFG_CCN3: begin
                    for (int c = 0; c < CHN; c++) begin
                        if (2'(i_cfg_index - trk2m_pkg::CFG_CCN0) == 2'(c)) begin
                            r_ccn[c] <= i_cfg_data;
                        end
                    end
                end
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        w_cnt_ok = 1'b1;
        for (int c = 0; c < CHN; c++) begin
            if (r_count[c] > CW'(HD)) begin
                w_cnt_ok = 1'b0;
            end
        end
    end

    `include "assert_macros.svh"

    `ASSERT_AT(a_hold_list_bounded, i_clk, i_rst_n, w_cnt_ok, "hold count beyond hold depth")
    `ASSERT_NEXT(a_last_ends_job, i_clk, i_rst_n, w_emit && w_msg.last, r_state == S_IDLE, "sequencer busy after final message")

endmodule

// File: rtl/tracker_byte_to_midi_converter.sv
// Tracker link byte to MIDI message converter, top level.
// Path: an accepted byte goes through a queue slot and the decode state to the result register.
// Throughput: one message per cycle from the sequencer while the result side pops; each item
// also passes the idle and decode states, and Stop with all hold lists full gives 21 messages.
// Reset: synchronous active-low i_rst_n clears time, command latch, queues and note tracking
// and loads config defaults; the held-note store is not cleared. Depends on trk2m_pkg.
module tracker_byte_to_midi_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // link side, queue style
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [6:0]  i_rx_byte,
    // result side, queue style
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_msg_kind,
    output logic [1:0]  o_midi_channel,
    output logic [6:0]  o_data_one,
    output logic [6:0]  o_data_two,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [48:0] i_cfg_data
);

    // Front end decodes bytes into jobs (note, CC, program, start, stop) and
    // stamps each with the current millisecond count, so the sequencer can
    // judge hold expiry against the time the byte arrived, even when it is
    // still busy with an earlier job such as a long Stop flush.
    logic             w_q_push, w_q_full, w_q_empty, w_q_pop;
    trk2m_pkg::t_job  w_q_job, w_q_head;
    logic             w_out_valid;
    trk2m_pkg::t_msg  w_out;

    assign full        = w_q_full;
    assign o_cfg_ready = 1'b1;   // the user must write config only while idle; the block does not enforce it

    trk2m_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_func    (i_func),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_job   (w_q_job)
    );

    // two-entry job queue lets the link keep delivering while the
    // sequencer waits on the result side
    trk2m_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_job),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // Sequencer emits one message per cycle into its result register while it is free or popped;
    // flushes walk the hold list one entry per message.
    trk2m_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign empty          = !w_out_valid;
    assign o_msg_kind     = w_out.kind;
    assign o_midi_channel = w_out.ch;
    assign o_data_one     = w_out.d1;
    assign o_data_two     = w_out.d2;
    assign o_last         = w_out.last;

endmodule
